@@ src/sorted_list_insert_delete_defines.svh @@
// Assertion macros used by the sorted list top level.
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SLI_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Condition on one edge implies a consequence on the next edge.
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sli_pkg.sv @@
// Types and constants of the sorted list block.
package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item;
    logic [4:0]         entry_count;
    logic               last;
  } out_beat_t;

  // Broadcast to every cell.
  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
    logic [CNT_W-1:0]   count;
  } cell_ctl_t;

  // Compare flags a cell hands to the next cell up the chain and the controller.
  typedef struct packed {
    logic gt;   // entry above value, or first free slot
    logic ge;   // held entry at or above value
    logic hit;  // first entry at or above value equals value
  } cell_stat_t;

endpackage

@@ src/sorted_list_insert_delete.sv @@
// Top level of the sorted list: cell chain, dump sequencer and result register.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-----------------------------
//   in      | in  | in_valid/in_stall  | in_data  (opcode, value)
//   out     | out | out_valid/out_stall| out_data (status, item,
//           |     |                    |   entry_count, last)
//
// Insert and delete settle in the cell chain: one beat in, one beat out, a
// new item every cycle while the result register drains. Dump of a
// non-empty list takes the input beat and then emits one beat per entry
// held; an empty dump answers with one ST_EMPTY beat like insert and delete.
// The chain rotates left one slot per emitted beat and is back in order
// after the last. Reset clears the entry count, the sequencer and the result
// valid; cell contents are left as they are and are never read before being
// written. out_stall freezes the result register and, through in_stall, the
// input.
module sorted_list_insert_delete (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sli_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sli_pkg::out_beat_t out_data
);

  localparam int CAP = sli_pkg::CAPACITY;
  localparam int CW  = sli_pkg::CNT_W;

  sli_pkg::state_t     state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       dump_idx_r, dump_idx_nxt;
  sli_pkg::out_beat_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;

  logic                slot_free;
  logic                in_acc;
  logic                full;
  logic                found;
  logic                dump_last;
  sli_pkg::cell_ctl_t  ctl;

  logic signed [31:0]  entry_vec [CAP];
  sli_pkg::cell_stat_t stat_vec  [CAP];
  logic [CAP-1:0]      hit_vec;

  // Result register is free when empty or being taken this cycle.
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r == sli_pkg::S_DUMP) || !slot_free;
  assign in_acc    = in_valid && !in_stall;
  assign full      = count_r == CW'(CAP);
  assign found     = |hit_vec;
  assign dump_last = (dump_idx_r + CW'(1)) == count_r;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Chain control.
  always_comb begin
    ctl.value = in_data.value;
    ctl.count = count_r;
    ctl.op    = sli_pkg::CELL_HOLD;
    if (in_acc && (in_data.opcode == sli_pkg::OP_INSERT) && !full) begin
      ctl.op = sli_pkg::CELL_INS;
    end else if (in_acc && (in_data.opcode == sli_pkg::OP_DELETE)) begin
      ctl.op = sli_pkg::CELL_DEL;
    end else if ((state_r == sli_pkg::S_DUMP) && slot_free) begin
      ctl.op = sli_pkg::CELL_ROT;
    end
  end

  // Cell chain; cell 0 holds the smallest entry.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    sli_pkg::cell_stat_t left_stat;
    logic signed [31:0]  left_entry;
    logic signed [31:0]  right_entry;

    if (i == 0) begin : g_head
      assign left_stat  = '0;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_stat  = stat_vec[i-1];
      assign left_entry = entry_vec[i-1];
    end

    if (i == CAP - 1) begin : g_tail
      assign right_entry = entry_vec[i];
    end else begin : g_body
      assign right_entry = entry_vec[i+1];
    end

    sli_cell u_cell (
      .clk         (clk),
      .cell_idx    (CW'(i)),
      .ctl         (ctl),
      .del_found   (found),
      .left_stat   (left_stat),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .head_entry  (entry_vec[0]),
      .entry       (entry_vec[i]),
      .stat        (stat_vec[i])
    );

    assign hit_vec[i] = stat_vec[i].hit;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sli_pkg::S_IDLE: begin
        if (in_acc && (in_data.opcode == sli_pkg::OP_DUMP) && (count_r != '0)) begin
          state_nxt = sli_pkg::S_DUMP;
        end
      end
      sli_pkg::S_DUMP: begin
        if (slot_free && dump_last) begin
          state_nxt = sli_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sli_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs: result beat, count and dump index.
  always_comb begin
    out_load     = 1'b0;
    out_nxt      = out_r;
    count_nxt    = count_r;
    dump_idx_nxt = dump_idx_r;
    case (state_r)
      sli_pkg::S_IDLE: begin
        if (in_acc) begin
          out_nxt.item = in_data.value;
          out_nxt.last = 1'b1;
          case (in_data.opcode)
            sli_pkg::OP_INSERT: begin
              out_load = 1'b1;
              if (full) begin
                out_nxt.status = sli_pkg::ST_FULL;
              end else begin
                out_nxt.status = sli_pkg::ST_OK;
                count_nxt      = count_r + CW'(1);
              end
            end
            sli_pkg::OP_DELETE: begin
              out_load = 1'b1;
              if (found) begin
                out_nxt.status = sli_pkg::ST_OK;
                count_nxt      = count_r - CW'(1);
              end else begin
                out_nxt.status = sli_pkg::ST_NOT_FOUND;
              end
            end
            sli_pkg::OP_DUMP: begin
              dump_idx_nxt = '0;
              if (count_r == '0) begin
                out_load       = 1'b1;
                out_nxt.status = sli_pkg::ST_EMPTY;
                out_nxt.item   = '0;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
          out_nxt.entry_count = 5'(count_nxt);
        end
      end
      sli_pkg::S_DUMP: begin
        if (slot_free) begin
          out_load            = 1'b1;
          out_nxt.status      = sli_pkg::ST_OK;
          out_nxt.item        = entry_vec[0];
          out_nxt.entry_count = 5'(count_r);
          out_nxt.last        = dump_last;
          dump_idx_nxt        = dump_idx_r + CW'(1);
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sli_pkg::S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

`include "sorted_list_insert_delete_defines.svh"

  `SLI_ASSERT(a_count_bound, count_r <= CW'(CAP), "entry count above capacity")
  `SLI_ASSERT(a_no_accept_in_dump, !((state_r == sli_pkg::S_DUMP) && in_acc), "beat taken during dump")
  `SLI_ASSERT_NEXT(a_insert_grows, in_acc && (in_data.opcode == sli_pkg::OP_INSERT) && !full, count_r == $past(count_r) + CW'(1), "insert did not grow the list")
  `SLI_ASSERT_NEXT(a_dump_beat, (state_r == sli_pkg::S_DUMP) && slot_free, out_valid_r && (out_r.status == sli_pkg::ST_OK), "dump step without result beat")

endmodule

@@ src/sli_cell.sv @@
// One list slot: holds an entry, compares it and shifts with its neighbors.
module sli_cell (
  input  logic                          clk,
  input  logic [sli_pkg::CNT_W-1:0]     cell_idx,
  input  sli_pkg::cell_ctl_t            ctl,
  input  logic                          del_found,
  input  sli_pkg::cell_stat_t           left_stat,
  input  logic signed [31:0]            left_entry,
  input  logic signed [31:0]            right_entry,
  input  logic signed [31:0]            head_entry,
  output logic signed [31:0]            entry,
  output sli_pkg::cell_stat_t           stat
);

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;
  logic               in_list;
  logic               at_end;
  logic               is_tail;

  assign in_list = cell_idx < ctl.count;
  assign at_end  = cell_idx == ctl.count;
  assign is_tail = (cell_idx + sli_pkg::CNT_W'(1)) == ctl.count;

  assign stat.gt  = at_end || (in_list && (entry_r > ctl.value));
  assign stat.ge  = in_list && (entry_r >= ctl.value);
  assign stat.hit = stat.ge && !left_stat.ge && (entry_r == ctl.value);
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      sli_pkg::CELL_INS: begin
        if (stat.gt) begin
          entry_nxt = left_stat.gt ? left_entry : ctl.value;
        end
      end
      sli_pkg::CELL_DEL: begin
        if (del_found && stat.ge) begin
          entry_nxt = right_entry;
        end
      end
      sli_pkg::CELL_ROT: begin
        if (in_list) begin
          entry_nxt = is_tail ? head_entry : right_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
